FILE: sv/cqp_pkg.sv
// Shared types and constants for the circular queue with indexed peek.
// Depends on nothing; every other file takes names from here by scope.
package cqp_pkg;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;     // latch the accepted item
    logic exec;     // apply the operation, launch slot read if needed
    logic capture;  // registered slot read data is valid
    logic load;     // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;
  } sts_t;

endpackage

FILE: sv/cqp_in_if.sv
// Input channel of the circular queue: valid/ready handshake with op, value, index.
// Depends on cqp_pkg for field widths.
interface cqp_in_if;
  logic                         valid;
  logic                         ready;
  logic [cqp_pkg::OP_W-1:0]     op;
  logic [cqp_pkg::VALUE_W-1:0]  value;
  logic [cqp_pkg::INDEX_W-1:0]  index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);
endinterface

FILE: sv/cqp_out_if.sv
// Result channel of the circular queue: valid/ready handshake with the result fields.
// Depends on cqp_pkg for field widths.
interface cqp_out_if;
  logic                          valid;
  logic                          ready;
  logic [cqp_pkg::VALUE_W-1:0]   peek_value;
  logic [cqp_pkg::VALUE_W-1:0]   head_value;
  logic [cqp_pkg::VALUE_W-1:0]   tail_value;
  logic [cqp_pkg::COUNT_W-1:0]   count;
  logic [cqp_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output peek_value, output head_value, output tail_value,
                  output count, output status, input ready);
  modport sink   (input valid, input peek_value, input head_value, input tail_value,
                  input count, input status, output ready);
endinterface

FILE: sv/circular_queue_with_indexed_peek.sv
// Top level of the circular queue with indexed peek: joins controller and datapath.
// Depends on cqp_pkg, cqp_in_if, cqp_out_if, cqp_ctrl, cqp_dp.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    op, value, index
//   rsp      out  valid / ready    peek_value, head_value, tail_value, count, status
//
// Push, error and reserved items pass idle, execute and load; the result register
// is loaded as the load step ends, and no new item is accepted before that.
// A pop that leaves elements behind and a peek that hits add a read step after
// execute: the registered read of the slot memory's single read port.
// Synchronous reset empties the queue at once; slot storage is not cleared.
// A stalled rsp holds its result; the next item is accepted meanwhile and waits
// in the load step until the result register is taken.
module circular_queue_with_indexed_peek #(
  parameter int CAPACITY   = 1024,
  parameter int ELEM_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  cqp_in_if.sink    req,
  cqp_out_if.source rsp
);

  cqp_pkg::cmd_t cmd;
  cqp_pkg::sts_t sts;

  cqp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cqp_dp #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .op         (req.op),
    .value      (req.value),
    .index      (req.index),
    .peek_value (rsp.peek_value),
    .head_value (rsp.head_value),
    .tail_value (rsp.tail_value),
    .count      (rsp.count),
    .status     (rsp.status)
  );

endmodule

FILE: sv/cqp_ctrl.sv
// Sequencing state machine of the circular queue: accept, execute, read, load.
// Depends on cqp_pkg for state, command and status types.
module cqp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  cqp_pkg::sts_t sts,
  output cqp_pkg::cmd_t cmd
);

  cqp_pkg::state_t state, state_next;
  logic            out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cqp_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    req_ready   = 1'b0;
    unique case (state)
      cqp_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.take  = req_valid;
        if (req_valid) state_next = cqp_pkg::S_EXEC;
      end
      cqp_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_read ? cqp_pkg::S_READ : cqp_pkg::S_LOAD;
      end
      cqp_pkg::S_READ: begin
        cmd.capture = 1'b1;
        state_next  = cqp_pkg::S_LOAD;
      end
      cqp_pkg::S_LOAD: begin
        // output register frees up in the same cycle it is taken
        cmd.load = !out_valid || rsp_ready;
        if (cmd.load) state_next = cqp_pkg::S_IDLE;
      end
      default: state_next = cqp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load)       out_valid_next = 1'b1;
    else if (rsp_ready) out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

  assign rsp_valid = out_valid;

  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == cqp_pkg::S_EXEC)
    else $error("accepted item did not enter execute");

  a_read_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == cqp_pkg::S_READ |-> $past(state) == cqp_pkg::S_EXEC)
    else $error("read state not preceded by execute");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

endmodule

FILE: sv/cqp_dp.sv
// Datapath of the circular queue: pointers, count, cached head/tail values,
// slot memory with one write and one registered read port. Depends on cqp_pkg.
module cqp_dp #(
  parameter int CAPACITY   = 1024,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cqp_pkg::cmd_t                    cmd,
  output cqp_pkg::sts_t                    sts,
  input  logic [cqp_pkg::OP_W-1:0]         op,
  input  logic [cqp_pkg::VALUE_W-1:0]      value,
  input  logic [cqp_pkg::INDEX_W-1:0]      index,
  output logic [cqp_pkg::VALUE_W-1:0]      peek_value,
  output logic [cqp_pkg::VALUE_W-1:0]      head_value,
  output logic [cqp_pkg::VALUE_W-1:0]      tail_value,
  output logic [cqp_pkg::COUNT_W-1:0]      count,
  output logic [cqp_pkg::STATUS_W-1:0]     status
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((PW > cqp_pkg::INDEX_W) ? PW : cqp_pkg::INDEX_W) + 1;

  logic [cqp_pkg::OP_W-1:0]     op_r;
  logic [ELEM_WIDTH-1:0]        wdata;
  logic [cqp_pkg::INDEX_W-1:0]  index_r;

  logic [PW-1:0]          head_ptr, tail_ptr, head_inc, tail_inc, peek_pos, rd_addr;
  logic [CW-1:0]          fill;
  logic [ELEM_WIDTH-1:0]  head_val, tail_val, peek_val, rdata;
  logic [cqp_pkg::STATUS_W-1:0] status_r, status_calc;
  logic                   rd_to_head;
  logic                   full, empty, idx_ok, mem_we, mem_re;
  logic [XW-1:0]          pos_sum;

  logic [ELEM_WIDTH-1:0]  slots [CAPACITY];

  assign full     = fill == CW'(CAPACITY);
  assign empty    = fill == '0;
  assign head_inc = (head_ptr == PW'(CAPACITY - 1)) ? '0 : head_ptr + 1'b1;
  assign tail_inc = (tail_ptr == PW'(CAPACITY - 1)) ? '0 : tail_ptr + 1'b1;
  assign idx_ok   = XW'(index_r) < XW'(fill);
  // head + index stays below twice the capacity whenever the peek hits
  assign pos_sum  = XW'(head_ptr) + XW'(index_r);
  assign peek_pos = (pos_sum >= XW'(CAPACITY)) ? PW'(pos_sum - XW'(CAPACITY))
                                               : PW'(pos_sum);

  always_comb begin
    status_calc   = cqp_pkg::ST_OK;
    sts.need_read = 1'b0;
    if (op_r == cqp_pkg::OP_PUSH) begin
      if (full) status_calc = cqp_pkg::ST_FULL;
    end else if (op_r == cqp_pkg::OP_POP) begin
      if (empty) status_calc = cqp_pkg::ST_EMPTY;
      else       sts.need_read = fill > CW'(1);  // new head must be fetched
    end else if (op_r == cqp_pkg::OP_PEEK) begin
      if (empty)        status_calc = cqp_pkg::ST_EMPTY;
      else if (!idx_ok) status_calc = cqp_pkg::ST_RANGE;
      else              sts.need_read = 1'b1;
    end
  end

  assign mem_we  = cmd.exec && op_r == cqp_pkg::OP_PUSH && !full;
  assign mem_re  = cmd.exec && sts.need_read;
  assign rd_addr = (op_r == cqp_pkg::OP_POP) ? head_inc : peek_pos;

  always_ff @(posedge clk) begin
    if (mem_we) slots[tail_inc] <= wdata;
    if (mem_re) rdata <= slots[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= PW'(CAPACITY - 1);
      fill     <= '0;
    end else if (cmd.exec) begin
      if (mem_we) begin
        tail_ptr <= tail_inc;
        fill     <= fill + 1'b1;
      end else if (op_r == cqp_pkg::OP_POP && !empty) begin
        head_ptr <= head_inc;
        fill     <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r    <= op;
      wdata   <= ELEM_WIDTH'(value);
      index_r <= index;
    end
    if (cmd.exec) begin
      status_r   <= status_calc;
      peek_val   <= '0;
      rd_to_head <= op_r == cqp_pkg::OP_POP;
      if (mem_we) begin
        tail_val <= wdata;
        if (empty) head_val <= wdata;
      end
    end
    if (cmd.capture) begin
      if (rd_to_head) head_val <= rdata;
      else            peek_val <= rdata;
    end
    if (cmd.load) begin
      peek_value <= cqp_pkg::VALUE_W'(peek_val);
      head_value <= empty ? '0 : cqp_pkg::VALUE_W'(head_val);
      tail_value <= empty ? '0 : cqp_pkg::VALUE_W'(tail_val);
      count      <= cqp_pkg::COUNT_W'(fill);
      status     <= status_r;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op_r == cqp_pkg::OP_PUSH && full) |=> $stable(fill) && $stable(tail_ptr))
    else $error("push while full changed the queue");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op_r == cqp_pkg::OP_POP && !empty) |=> fill == CW'($past(fill) - 1'b1))
    else $error("pop did not decrement fill count");

endmodule

FILE: dv/cqp_queue_checker.sv
// Result checker for the circular queue with indexed peek: predicts every result.
// Watches the req and rsp channels; depends on cqp_pkg, cqp_in_if and cqp_out_if.
`timescale 1ns / 100ps

module cqp_queue_checker #(
  parameter int DEPTH = 1024
) (
  input logic clk,
  input logic rst,
  cqp_in_if   req,
  cqp_out_if  rsp,
  output int  mismatches,
  output int  outstanding
);

  typedef struct packed {
    logic [cqp_pkg::VALUE_W-1:0]  peek_value;
    logic [cqp_pkg::VALUE_W-1:0]  head_value;
    logic [cqp_pkg::VALUE_W-1:0]  tail_value;
    logic [cqp_pkg::COUNT_W-1:0]  count;
    logic [cqp_pkg::STATUS_W-1:0] status;
  } queue_result_t;

  logic [cqp_pkg::VALUE_W-1:0] slot_mem [DEPTH];
  int unsigned        head_pos;
  int unsigned        tail_pos;
  int unsigned        fill;
  int                 fail_count = 0;
  queue_result_t      expected_results [$];
  queue_result_t      want;

  // applies one item to the shadow queue and returns the result it must produce
  function automatic queue_result_t apply_queue_op(
      input logic [cqp_pkg::OP_W-1:0]    op,
      input logic [cqp_pkg::VALUE_W-1:0] value,
      input logic [cqp_pkg::INDEX_W-1:0] index);
    queue_result_t r;
    r = '0;
    r.status = cqp_pkg::ST_OK;
    case (op)
      cqp_pkg::OP_PUSH: begin
        if (fill >= DEPTH) begin
          r.status = cqp_pkg::ST_FULL;
        end else begin
          tail_pos = (tail_pos + 1) % DEPTH;
          slot_mem[tail_pos] = value;
          fill++;
        end
      end
      cqp_pkg::OP_POP: begin
        if (fill == 0) begin
          r.status = cqp_pkg::ST_EMPTY;
        end else begin
          head_pos = (head_pos + 1) % DEPTH;
          fill--;
        end
      end
      cqp_pkg::OP_PEEK: begin
        if (fill == 0) begin
          r.status = cqp_pkg::ST_EMPTY;
        end else if (index >= fill) begin
          r.status = cqp_pkg::ST_RANGE;
        end else begin
          r.peek_value = slot_mem[(head_pos + index) % DEPTH];
        end
      end
      default: ;
    endcase
    if (fill != 0) begin
      r.head_value = slot_mem[head_pos];
      r.tail_value = slot_mem[tail_pos];
    end
    r.count = fill[cqp_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [cqp_pkg::VALUE_W-1:0] exp_val,
                             input logic [cqp_pkg::VALUE_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_pos = 0;
      tail_pos = DEPTH - 1;
      fill     = 0;
      expected_results.delete();
    end else begin
      // result first: a result never answers the item accepted on the same edge
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0h count %0h",
                   $time, rsp.status, rsp.count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("peek_value", want.peek_value, rsp.peek_value);
          check_field("head_value", want.head_value, rsp.head_value);
          check_field("tail_value", want.tail_value, rsp.tail_value);
          check_field("count", cqp_pkg::VALUE_W'(want.count), cqp_pkg::VALUE_W'(rsp.count));
          check_field("status", cqp_pkg::VALUE_W'(want.status),
                      cqp_pkg::VALUE_W'(rsp.status));
        end
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(apply_queue_op(req.op, req.value, req.index));
      end
    end
    outstanding <= expected_results.size();
    mismatches  <= fail_count;
  end

endmodule

FILE: dv/circular_queue_with_indexed_peek_test.sv
// Testbench top for the circular queue with indexed peek: clock, reset, stimulus, verdict.
// Depends on cqp_pkg, cqp_in_if, cqp_out_if, the block and cqp_queue_checker.
`timescale 1ns / 100ps

module circular_queue_with_indexed_peek_test;

  localparam int                       DEPTH          = 1024;
  localparam logic [cqp_pkg::OP_W-1:0] OP_RESERVED    = 2'd3;
  localparam int                       RANDOM_ITEMS   = 80;
  localparam int                       LONG_HOLD      = 400;
  localparam int                       DRAIN_CYCLES   = 12;
  localparam int                       WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cqp_in_if  req_ch ();
  cqp_out_if rsp_ch ();

  int mismatches;
  int outstanding;
  int occupancy      = 0;
  int burst_left     = 0;
  int quiet_cycles   = 0;
  int items_left;
  int seg_len;
  int push_pct;
  int pop_pct;
  int stall_mode;
  int stretch;
  bit offering       = 1'b0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;

  always #1 clk = ~clk;

  circular_queue_with_indexed_peek #(
    .CAPACITY   (DEPTH),
    .ELEM_WIDTH (cqp_pkg::VALUE_W)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  cqp_queue_checker #(
    .DEPTH (DEPTH)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic logic [cqp_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // mostly in range, some right at the count, some anywhere
  function automatic logic [cqp_pkg::INDEX_W-1:0] pick_index();
    int pick;
    pick = $urandom_range(0, 19);
    if (occupancy > 0 && pick < 14) return cqp_pkg::INDEX_W'($urandom_range(0, occupancy - 1));
    if (pick < 17 && occupancy < DEPTH) return cqp_pkg::INDEX_W'(occupancy);
    return cqp_pkg::INDEX_W'($urandom_range(0, DEPTH - 1));
  endfunction

  // offer one item, wait for it to be taken, then maybe end the burst
  task automatic send_item(input logic [cqp_pkg::OP_W-1:0] op,
                           input logic [cqp_pkg::VALUE_W-1:0] value,
                           input logic [cqp_pkg::INDEX_W-1:0] index);
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= value;
    req_ch.index <= index;
    offering = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op == cqp_pkg::OP_PUSH && occupancy < DEPTH) occupancy++;
    if (op == cqp_pkg::OP_POP && occupancy > 0) occupancy--;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic random_item(input int push_w, input int pop_w);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < push_w) send_item(cqp_pkg::OP_PUSH, pick_value(), pick_index());
    else if (pick < push_w + pop_w) send_item(cqp_pkg::OP_POP, pick_value(), pick_index());
    else if (pick < 98) send_item(cqp_pkg::OP_PEEK, pick_value(), pick_index());
    else send_item(OP_RESERVED, pick_value(), pick_index());
  endtask

  // stop offering and let every outstanding result come back
  task automatic pause_until_drained();
    if (offering) begin
      req_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // result side: stall patterns in stretches, plus the long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall_mode = $urandom_range(0, 3);
        stretch    = $urandom_range(4, 40);
        repeat (stretch) begin
          case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op    = cqp_pkg::OP_PUSH;
    req_ch.value = '0;
    req_ch.index = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty errors, extremes, range edges, reserved op
    send_item(cqp_pkg::OP_POP, '0, '0);
    send_item(cqp_pkg::OP_PEEK, '1, '1);
    send_item(OP_RESERVED, 32'h1234_5678, 10'h155);
    send_item(cqp_pkg::OP_PUSH, '0, '1);
    send_item(cqp_pkg::OP_PUSH, '1, '0);
    send_item(cqp_pkg::OP_PUSH, 32'hAAAA_AAAA, 10'h2AA);
    send_item(cqp_pkg::OP_PUSH, 32'h5555_5555, 10'h155);
    send_item(cqp_pkg::OP_PEEK, '0, 10'd0);
    send_item(cqp_pkg::OP_PEEK, '0, 10'd1);
    send_item(cqp_pkg::OP_PEEK, '0, 10'd3);
    send_item(cqp_pkg::OP_PEEK, '0, 10'd4);
    send_item(cqp_pkg::OP_PEEK, '0, '1);
    send_item(OP_RESERVED, '1, '1);
    send_item(cqp_pkg::OP_POP, '0, '0);
    send_item(cqp_pkg::OP_POP, '0, '0);
    send_item(cqp_pkg::OP_POP, '0, '0);
    send_item(cqp_pkg::OP_PEEK, '0, 10'd0);
    send_item(cqp_pkg::OP_POP, '0, '0);
    send_item(cqp_pkg::OP_POP, '0, '0);
    send_item(cqp_pkg::OP_PEEK, '0, 10'd0);
    send_item(cqp_pkg::OP_PUSH, 32'hDEAD_BEEF, '0);
    send_item(cqp_pkg::OP_PEEK, '0, 10'd0);

    // fill to capacity with a long result-side hold-off at the start, then overflow and wrap
    long_hold_req = 1'b1;
    while (occupancy < DEPTH) begin
      if ($urandom_range(0, 31) == 0) send_item(cqp_pkg::OP_PEEK, pick_value(), pick_index());
      else send_item(cqp_pkg::OP_PUSH, pick_value(), pick_index());
    end
    send_item(cqp_pkg::OP_PUSH, '1, '0);
    send_item(cqp_pkg::OP_PUSH, '0, '1);
    send_item(cqp_pkg::OP_PUSH, pick_value(), pick_index());
    send_item(cqp_pkg::OP_PEEK, '0, '1);
    send_item(cqp_pkg::OP_PEEK, '0, 10'd0);
    send_item(OP_RESERVED, pick_value(), pick_index());
    send_item(cqp_pkg::OP_POP, '0, '0);
    send_item(cqp_pkg::OP_PEEK, '0, '1);
    send_item(cqp_pkg::OP_PUSH, pick_value(), '0);
    send_item(cqp_pkg::OP_PUSH, pick_value(), '0);
    pause_until_drained();

    // random: segments that grow, shrink or hover around a level
    items_left = RANDOM_ITEMS;
    while (items_left > 0) begin
      seg_len = $urandom_range(40, 150);
      if (seg_len > items_left) seg_len = items_left;
      case ($urandom_range(0, 2))
        0:       begin push_pct = 60; pop_pct = 25; end
        1:       begin push_pct = 20; pop_pct = 65; end
        default: begin push_pct = 40; pop_pct = 40; end
      endcase
      repeat (seg_len) random_item(push_pct, pop_pct);
      items_left -= seg_len;
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
